[rtl/core/dpr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpr_pkg
// shared types and constants for the disparity to point reprojection block
// ----------------------------------------------------------------------------
package dpr_pkg;

    localparam int FRAC_BITS_DEF = 24;
    localparam int MAX_DIM       = 4096;

    localparam int COORD_W = 48;
    localparam int PIX_W   = 12;
    localparam int DISP_W  = 8;
    localparam int COLOR_W = 8;
    localparam int STEP_W  = 7;
    localparam int CFG_IDX_W = 3;

    // numerator magnitude, signed weight, weight magnitude
    localparam int NUM_W = COORD_W + 1;
    localparam int W_W   = COORD_W + DISP_W + 1;
    localparam int B_W   = W_W - 1;

    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(10);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OFFSET_X      = 3'd0,
        REG_OFFSET_Y      = 3'd1,
        REG_FOCAL         = 3'd2,
        REG_DISP_SCALE    = 3'd3,
        REG_WEIGHT_OFFSET = 3'd4,
        REG_COLUMN_STEP   = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [PIX_W-1:0]   pixel_row;
        logic [PIX_W-1:0]   pixel_column;
        logic [DISP_W-1:0]  disparity;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } pixel_in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
        logic [COLOR_W-1:0]        out_red;
        logic [COLOR_W-1:0]        out_green;
        logic [COLOR_W-1:0]        out_blue;
        logic                      overflow;
    } point_out_t;

    typedef struct packed {
        logic [NUM_W-1:0] mag;
        logic [B_W-1:0]   div;
        logic             neg;
    } lane_in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] coord;
        logic                      ovf;
    } lane_out_t;

endpackage

[rtl/core/disparity_to_point_reproject.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// disparity_to_point_reproject
// stereo disparity pixel to 3d point reprojection, fully pipelined
// ----------------------------------------------------------------------------
// Takes one pixel transfer per clock and returns the point x, y, z in signed
// fixed point with FRAC_BITS fraction bits, with the colour passed through.
// Pixels off the column step grid, with zero disparity or out of image range
// are dropped and give no output transfer. The pipeline holds three front
// stages (input capture, weight multiply, magnitudes), 49 divider stages
// (one setup stage plus one quotient bit per stage for 48 bits) and the
// output register. Throughput is one pixel per clock; the whole pipeline
// holds while a finished point waits on out_ready. Configuration is taken
// at any time on the cfg channel but is only meant to change while idle.
module disparity_to_point_reproject #(
    parameter int FRAC_BITS = dpr_pkg::FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  dpr_pkg::pixel_in_t              in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output dpr_pkg::point_out_t             out_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [dpr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dpr_pkg::COORD_W-1:0]     cfg_data
);
    import dpr_pkg::*;

    localparam int LANE_LAT = COORD_W + 1;
    localparam int FX_W     = PIX_W + 1 + FRAC_BITS;

    // side data that travels along the divider lanes
    typedef struct packed {
        logic [PIX_W-1:0]   col;
        logic [STEP_W-1:0]  rem;
        logic               keep;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } side_t;

    // configuration registers
    logic signed [COORD_W-1:0] q_offset_x_reg;
    logic signed [COORD_W-1:0] q_offset_y_reg;
    logic signed [COORD_W-1:0] q_focal_reg;
    logic signed [COORD_W-1:0] q_disp_scale_reg;
    logic signed [COORD_W-1:0] q_weight_offset_reg;
    logic [STEP_W-1:0]         column_step_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_offset_x_reg      <= '0;
            q_offset_y_reg      <= '0;
            q_focal_reg         <= '0;
            q_disp_scale_reg    <= '0;
            q_weight_offset_reg <= '0;
            column_step_reg     <= STEP_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_OFFSET_X:      q_offset_x_reg      <= $signed(cfg_data);
                REG_OFFSET_Y:      q_offset_y_reg      <= $signed(cfg_data);
                REG_FOCAL:         q_focal_reg         <= $signed(cfg_data);
                REG_DISP_SCALE:    q_disp_scale_reg    <= $signed(cfg_data);
                REG_WEIGHT_OFFSET: q_weight_offset_reg <= $signed(cfg_data);
                REG_COLUMN_STEP:   column_step_reg     <= cfg_data[STEP_W-1:0];
                default:           ;
            endcase
        end
    end

    // a zero step behaves as one
    logic [STEP_W-1:0] step_eff;
    assign step_eff = (column_step_reg == '0) ? STEP_W'(1) : column_step_reg;

    // whole pipeline moves when the output register is free or being taken
    logic       advance;
    logic       out_valid_reg;
    point_out_t out_data_reg;

    assign advance   = !out_valid_reg || out_ready;
    assign in_ready  = advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // stage 1: input capture
    logic      s1_valid_reg;
    pixel_in_t s1_pix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_pix_reg <= in_data;
        end
    end

    // stage 2: homogeneous weight and numerators
    logic signed [W_W-1:0]   prod;
    logic signed [W_W-1:0]   w_next;
    logic [FX_W-1:0]         col_fx;
    logic [FX_W-1:0]         row_fx;
    logic signed [NUM_W-1:0] nx_next;
    logic signed [NUM_W-1:0] ny_next;
    logic                    keep1;

    always_comb
    begin
        prod    = $signed({1'b0, s1_pix_reg.disparity}) * q_disp_scale_reg;
        w_next  = W_W'(q_weight_offset_reg) - prod;
        col_fx  = {1'b0, s1_pix_reg.pixel_column, {FRAC_BITS{1'b0}}};
        row_fx  = {1'b0, s1_pix_reg.pixel_row, {FRAC_BITS{1'b0}}};
        nx_next = NUM_W'($signed(col_fx)) + NUM_W'(q_offset_x_reg);
        ny_next = NUM_W'($signed(row_fx)) + NUM_W'(q_offset_y_reg);
        keep1   = (32'(s1_pix_reg.pixel_row) < MAX_DIM)
               && (32'(s1_pix_reg.pixel_column) < MAX_DIM)
               && (s1_pix_reg.disparity != '0);
    end

    logic                    s2_valid_reg;
    logic                    s2_keep_reg;
    pixel_in_t               s2_pix_reg;
    logic signed [W_W-1:0]   s2_w_reg;
    logic signed [NUM_W-1:0] s2_nx_reg;
    logic signed [NUM_W-1:0] s2_ny_reg;
    logic signed [NUM_W-1:0] s2_nz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_keep_reg <= keep1;
            s2_pix_reg  <= s1_pix_reg;
            s2_w_reg    <= w_next;
            s2_nx_reg   <= nx_next;
            s2_ny_reg   <= ny_next;
            s2_nz_reg   <= NUM_W'(q_focal_reg);
        end
    end

    // stage 3: magnitudes and quotient signs for the three lanes
    logic             w_neg;
    logic [W_W-1:0]   w_abs;
    lane_in_t         lx_next;
    lane_in_t         ly_next;
    lane_in_t         lz_next;

    always_comb
    begin
        w_neg       = s2_w_reg[W_W-1];
        w_abs       = w_neg ? W_W'(-s2_w_reg) : W_W'(s2_w_reg);
        lx_next.div = w_abs[B_W-1:0];
        ly_next.div = w_abs[B_W-1:0];
        lz_next.div = w_abs[B_W-1:0];
        lx_next.mag = s2_nx_reg[NUM_W-1] ? NUM_W'(-s2_nx_reg) : NUM_W'(s2_nx_reg);
        ly_next.mag = s2_ny_reg[NUM_W-1] ? NUM_W'(-s2_ny_reg) : NUM_W'(s2_ny_reg);
        lz_next.mag = s2_nz_reg[NUM_W-1] ? NUM_W'(-s2_nz_reg) : NUM_W'(s2_nz_reg);
        lx_next.neg = s2_nx_reg[NUM_W-1] ^ w_neg;
        ly_next.neg = s2_ny_reg[NUM_W-1] ^ w_neg;
        lz_next.neg = s2_nz_reg[NUM_W-1] ^ w_neg;
    end

    logic      s3_valid_reg;
    lane_in_t  s3_lx_reg;
    lane_in_t  s3_ly_reg;
    lane_in_t  s3_lz_reg;
    side_t     s3_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s3_lx_reg         <= lx_next;
            s3_ly_reg         <= ly_next;
            s3_lz_reg         <= lz_next;
            s3_side_reg.col   <= s2_pix_reg.pixel_column;
            s3_side_reg.rem   <= '0;
            s3_side_reg.keep  <= s2_keep_reg;
            s3_side_reg.red   <= s2_pix_reg.red;
            s3_side_reg.green <= s2_pix_reg.green;
            s3_side_reg.blue  <= s2_pix_reg.blue;
        end
    end

    // divider lanes
    lane_out_t lx_out;
    lane_out_t ly_out;
    lane_out_t lz_out;

    dpr_div_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x (
        .clk      (clk),
        .advance  (advance),
        .lane_in  (s3_lx_reg),
        .lane_out (lx_out)
    );

    dpr_div_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y (
        .clk      (clk),
        .advance  (advance),
        .lane_in  (s3_ly_reg),
        .lane_out (ly_out)
    );

    dpr_div_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_z (
        .clk      (clk),
        .advance  (advance),
        .lane_in  (s3_lz_reg),
        .lane_out (lz_out)
    );

    // side line in step with the lanes; the first stages also work out
    // column mod step, one column bit per stage
    logic  side_valid_reg [LANE_LAT];
    side_t side_reg       [LANE_LAT];

    for (genvar k = 0; k < LANE_LAT; k++)
    begin : g_side
        logic  prev_valid;
        side_t prev;
        side_t cur;

        if (k == 0)
        begin : g_first
            assign prev_valid = s3_valid_reg;
            assign prev       = s3_side_reg;
        end
        else
        begin : g_rest
            assign prev_valid = side_valid_reg[k-1];
            assign prev       = side_reg[k-1];
        end

        if (k < PIX_W)
        begin : g_mod
            logic [STEP_W:0] t;
            logic            ge;
            always_comb
            begin
                t       = {prev.rem, prev.col[PIX_W-1-k]};
                ge      = (t >= {1'b0, step_eff});
                cur     = prev;
                cur.rem = ge ? STEP_W'(t - {1'b0, step_eff}) : t[STEP_W-1:0];
            end
        end
        else
        begin : g_pass
            assign cur = prev;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                side_valid_reg[k] <= 1'b0;
            end
            else if (advance)
            begin
                side_valid_reg[k] <= prev_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                side_reg[k] <= cur;
            end
        end
    end

    // output register
    side_t side_last;
    assign side_last = side_reg[LANE_LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= side_valid_reg[LANE_LAT-1] && side_last.keep
                          && (side_last.rem == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg.point_x   <= lx_out.coord;
            out_data_reg.point_y   <= ly_out.coord;
            out_data_reg.point_z   <= lz_out.coord;
            out_data_reg.out_red   <= side_last.red;
            out_data_reg.out_green <= side_last.green;
            out_data_reg.out_blue  <= side_last.blue;
            out_data_reg.overflow  <= lx_out.ovf | ly_out.ovf | lz_out.ovf;
        end
    end

endmodule

[rtl/core/dpr_div_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpr_div_lane
// pipelined restoring divider, one quotient bit per stage, with saturation
// ----------------------------------------------------------------------------
module dpr_div_lane #(
    parameter int FRAC_BITS = dpr_pkg::FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              advance,
    input  dpr_pkg::lane_in_t lane_in,
    output dpr_pkg::lane_out_t lane_out
);
    import dpr_pkg::*;

    localparam int HI_W  = FRAC_BITS + 1;
    localparam int LO_W  = COORD_W - FRAC_BITS;
    localparam int DEPTH = COORD_W;
    localparam logic [COORD_W-1:0] LIM_POS = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] LIM_NEG = {1'b1, {(COORD_W-1){1'b0}}};

    logic [B_W-1:0]     rem_reg  [DEPTH+1];
    logic [COORD_W-1:0] lo_reg   [DEPTH+1];
    logic [COORD_W-1:0] q_reg    [DEPTH+1];
    logic [B_W-1:0]     div_reg  [DEPTH+1];
    logic               neg_reg  [DEPTH+1];
    logic               sat_reg  [DEPTH+1];
    logic               zero_reg [DEPTH+1];

    logic [HI_W-1:0] hi;
    assign hi = lane_in.mag[NUM_W-1 -: HI_W];

    // init stage: integer part already too big means saturation
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rem_reg[0]  <= B_W'(hi);
            lo_reg[0]   <= {lane_in.mag[LO_W-1:0], {FRAC_BITS{1'b0}}};
            q_reg[0]    <= '0;
            div_reg[0]  <= lane_in.div;
            neg_reg[0]  <= lane_in.neg;
            sat_reg[0]  <= ({{(B_W-HI_W){1'b0}}, hi} >= lane_in.div);
            zero_reg[0] <= (lane_in.mag == '0);
        end
    end

    for (genvar k = 1; k <= DEPTH; k++)
    begin : g_step
        logic [B_W:0] t;
        logic         ge;
        assign t  = {rem_reg[k-1], lo_reg[k-1][COORD_W-1]};
        assign ge = (t >= {1'b0, div_reg[k-1]});

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                rem_reg[k]  <= ge ? B_W'(t - {1'b0, div_reg[k-1]}) : t[B_W-1:0];
                lo_reg[k]   <= {lo_reg[k-1][COORD_W-2:0], 1'b0};
                q_reg[k]    <= {q_reg[k-1][COORD_W-2:0], ge};
                div_reg[k]  <= div_reg[k-1];
                neg_reg[k]  <= neg_reg[k-1];
                sat_reg[k]  <= sat_reg[k-1];
                zero_reg[k] <= zero_reg[k-1];
            end
        end
    end

    logic [COORD_W-1:0] lim;
    logic               over;
    logic [COORD_W-1:0] mag;

    always_comb
    begin
        lim  = neg_reg[DEPTH] ? LIM_NEG : LIM_POS;
        over = sat_reg[DEPTH] || (q_reg[DEPTH] > lim);
        mag  = over ? lim : q_reg[DEPTH];
        if (zero_reg[DEPTH])
        begin
            // zero numerator gives zero, flagged only for a zero weight
            lane_out.coord = '0;
            lane_out.ovf   = (div_reg[DEPTH] == '0);
        end
        else
        begin
            lane_out.coord = neg_reg[DEPTH] ? $signed(-mag) : $signed(mag);
            lane_out.ovf   = over;
        end
    end

endmodule

[rtl/core/dpr_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpr_checker
// port level checks for the reprojection block
// ----------------------------------------------------------------------------
module dpr_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input dpr_pkg::point_out_t           out_data
);
    import dpr_pkg::*;

    // a waiting point stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output transfer dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("output payload changed while stalled");

    // empty output register never blocks the input
    a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

    // a new point only appears on a cycle where the pipeline moved
    a_out_moves: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_ready))
        else $error("output appeared without pipeline advance");

endmodule

bind disparity_to_point_reproject dpr_checker u_dpr_checker (.*);

[sim/disparity_to_point_reproject_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// disparity_to_point_reproject_tb
// self-checking bench for the disparity to 3d point reprojection block
// ----------------------------------------------------------------------------
// Drives pixels through a valid/ready handshake with random gaps, predicts
// each point with an exact fixed-point division model, and checks every
// output transfer against the oldest predicted point. The matrix and column
// step registers are reprogrammed between phases while the pipeline is empty.
// ----------------------------------------------------------------------------
module disparity_to_point_reproject_tb;
    import dpr_pkg::*;

    localparam int FRAC      = FRAC_BITS_DEF;
    localparam int DRAIN     = 80;      // pipeline depth plus margin
    localparam int CYCLE_CAP = 400000;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    pixel_in_t  in_data;
    logic       out_valid;
    logic       out_ready;
    point_out_t out_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COORD_W-1:0]   cfg_data;

    // predictor copy of the registers
    logic signed [COORD_W-1:0] m_off_x, m_off_y, m_focal, m_dscale, m_woff;
    logic [STEP_W-1:0]         m_step;

    point_out_t expected_points[$];
    int         mismatches = 0;
    int         cycles = 0;
    bit         stall_out;

    disparity_to_point_reproject DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // signed num * 2^FRAC / w, truncated toward zero, saturated to 48 bits
    function automatic logic [COORD_W:0] divide_coord(
        logic signed [63:0] num, logic signed [63:0] w);
        logic        neg;
        logic [63:0] a, b, lim, q, r;
        logic        sat;
        neg = (num < 0) != (w < 0);
        a   = num < 0 ? -num : num;
        b   = w < 0 ? -w : w;
        sat = 1'b0;
        if (w == 0)
        begin
            if (num > 0) return {1'b1, 48'h7FFF_FFFF_FFFF};
            if (num < 0) return {1'b1, 48'h8000_0000_0000};
            return {1'b1, 48'h0};
        end
        if (a == 0) return '0;
        lim = neg ? 64'h8000_0000_0000 : 64'h7FFF_FFFF_FFFF;
        q = a / b;
        r = a % b;
        if (q > lim) sat = 1'b1;
        for (int k = 0; k < FRAC && !sat; k++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= b)
            begin
                r = r - b;
                q[0] = 1'b1;
            end
            if (q > lim) sat = 1'b1;
        end
        if (sat) q = lim;
        if (neg) q = -q;
        return {sat, q[COORD_W-1:0]};
    endfunction

    // expected point for one pixel, returns 0 when the pixel is dropped
    function automatic bit reproject_pixel(pixel_in_t p, output point_out_t pt);
        logic [STEP_W-1:0]  st;
        logic signed [63:0] w, nx, ny, nz;
        logic [COORD_W:0]   rx, ry, rz;
        st = (m_step == 0) ? STEP_W'(1) : m_step;
        pt = '0;
        if (p.pixel_column % st != 0 || p.disparity == 0) return 0;
        w  = 64'(m_woff) - $signed({56'd0, p.disparity}) * 64'(m_dscale);
        nx = $signed({28'd0, p.pixel_column, 24'd0}) + 64'(m_off_x);
        ny = $signed({28'd0, p.pixel_row, 24'd0}) + 64'(m_off_y);
        nz = 64'(m_focal);
        rx = divide_coord(nx, w);
        ry = divide_coord(ny, w);
        rz = divide_coord(nz, w);
        pt.point_x   = rx[COORD_W-1:0];
        pt.point_y   = ry[COORD_W-1:0];
        pt.point_z   = rz[COORD_W-1:0];
        pt.out_red   = p.red;
        pt.out_green = p.green;
        pt.out_blue  = p.blue;
        pt.overflow  = rx[COORD_W] | ry[COORD_W] | rz[COORD_W];
        return 1;
    endfunction

    // output side: random stall per transfer, compare against oldest prediction
    initial
    begin
        int gap;
        point_out_t exp_pt;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = stall_out ? $urandom_range(0, 12) : 0;
            if (gap != 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            if (expected_points.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected point transfer %h", out_data);
            end
            else
            begin
                exp_pt = expected_points.pop_front();
                if (out_data !== exp_pt)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("point mismatch exp x=%h y=%h z=%h rgb=%h%h%h ov=%b",
                            exp_pt.point_x, exp_pt.point_y, exp_pt.point_z,
                            exp_pt.out_red, exp_pt.out_green, exp_pt.out_blue,
                            exp_pt.overflow);
                        $display("               act x=%h y=%h z=%h rgb=%h%h%h ov=%b",
                            out_data.point_x, out_data.point_y, out_data.point_z,
                            out_data.out_red, out_data.out_green, out_data.out_blue,
                            out_data.overflow);
                    end
                end
            end
            @(negedge clk);
        end
    end

    // one pixel transfer, prediction queued at acceptance
    task automatic send_pixel(pixel_in_t p, bit idle_gaps);
        point_out_t pt;
        int gap;
        gap = idle_gaps ? $urandom_range(0, 12) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data  <= p;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        if (reproject_pixel(p, pt)) expected_points.insert(expected_points.size(), pt);
        @(negedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [COORD_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_OFFSET_X:      m_off_x  = val;
            REG_OFFSET_Y:      m_off_y  = val;
            REG_FOCAL:         m_focal  = val;
            REG_DISP_SCALE:    m_dscale = val;
            REG_WEIGHT_OFFSET: m_woff   = val;
            REG_COLUMN_STEP:   m_step   = val[STEP_W-1:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    // wait for the pipeline to empty before touching the registers
    task automatic drain_pipe();
        in_valid <= 1'b0;
        while (expected_points.size() != 0) @(negedge clk);
        repeat (DRAIN) @(negedge clk);
    endtask

    task automatic load_matrix(logic [47:0] ox, logic [47:0] oy, logic [47:0] fz,
                               logic [47:0] ds, logic [47:0] wo, logic [6:0] st);
        drain_pipe();
        write_reg(REG_OFFSET_X, ox);
        write_reg(REG_OFFSET_Y, oy);
        write_reg(REG_FOCAL, fz);
        write_reg(REG_DISP_SCALE, ds);
        write_reg(REG_WEIGHT_OFFSET, wo);
        write_reg(REG_COLUMN_STEP, {41'd0, st});
        cfg_valid <= 1'b0;
    endtask

    function automatic pixel_in_t make_pixel(int r, int c, int d);
        pixel_in_t p;
        p.pixel_row    = r[11:0];
        p.pixel_column = c[11:0];
        p.disparity    = d[7:0];
        p.red          = 8'($urandom);
        p.green        = 8'($urandom);
        p.blue         = 8'($urandom);
        return p;
    endfunction

    function automatic logic [47:0] rand48();
        return 48'({$urandom, $urandom});
    endfunction

    // reset values: zero weight everywhere, default column step
    task automatic test_reset_defaults();
        send_pixel(make_pixel(0, 0, 1), 0);
        send_pixel(make_pixel(4095, 10, 255), 0);
        send_pixel(make_pixel(5, 11, 9), 0);
        send_pixel(make_pixel(0, 0, 0), 0);
    endtask

    // typical camera matrix, extremes of row, column, disparity, colour
    task automatic test_directed_extremes();
        pixel_in_t p;
        load_matrix(-48'sd320 <<< 24, -48'sd240 <<< 24, 48'sd700 <<< 24,
                    -48'sd8388608, 48'd0, 7'd1);
        send_pixel(make_pixel(0, 0, 1), 0);
        send_pixel(make_pixel(4095, 4095, 255), 0);
        send_pixel(make_pixel(240, 320, 64), 0);
        p = make_pixel(1, 2, 3);
        p.red = 8'hFF; p.green = 8'h00; p.blue = 8'hFF;
        send_pixel(p, 0);
        p.red = 8'h00; p.green = 8'hFF; p.blue = 8'h00;
        send_pixel(p, 0);
        send_pixel(make_pixel(100, 100, 0), 0);
    endtask

    // zero weight, saturating quotients, zero step and largest step
    task automatic test_special_cases();
        load_matrix(48'd5, -48'sd5, 48'd0, 48'd0, 48'd0, 7'd0);
        send_pixel(make_pixel(7, 3, 9), 0);
        send_pixel(make_pixel(0, 0, 9), 0);
        load_matrix(48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF,
                    48'd0, 48'd1, 7'd64);
        send_pixel(make_pixel(4095, 4032, 255), 0);
        send_pixel(make_pixel(0, 64, 1), 0);
        send_pixel(make_pixel(0, 63, 1), 0);
        load_matrix(48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000,
                    48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 7'd127);
        send_pixel(make_pixel(1, 127, 255), 0);
        send_pixel(make_pixel(1, 254, 1), 0);
        send_pixel(make_pixel(4095, 0, 128), 0);
    endtask

    // random matrices and pixels, mostly on the step grid with nonzero disparity
    task automatic test_random_pixels(int phases, int per_phase);
        pixel_in_t p;
        logic [6:0] st;
        int c;
        for (int ph = 0; ph < phases; ph++)
        begin
            st = (ph % 3 == 0) ? 7'($urandom_range(0, 127)) : 7'($urandom_range(1, 12));
            if (ph % 2 == 0)
                load_matrix(rand48(), rand48(), rand48(), rand48(), rand48(), st);
            else
                load_matrix(48'($signed($urandom_range(0, 2000)) - 1000) <<< 24,
                            48'($signed($urandom_range(0, 2000)) - 1000) <<< 24,
                            48'($urandom_range(1, 4000)) <<< 24,
                            48'($signed($urandom_range(0, 1 << 24)) - (1 << 23)),
                            48'($signed($urandom_range(0, 64)) - 32) <<< 20, st);
            stall_out = (ph % 4 != 3);
            for (int i = 0; i < per_phase; i++)
            begin
                c = $urandom_range(0, 4095);
                if ($urandom_range(0, 9) < 8 && st > 1) c = c - c % st;
                p = make_pixel($urandom_range(0, 4095), c,
                               $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 255));
                send_pixel(p, ph % 4 != 2);
            end
        end
        stall_out = 1'b1;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        stall_out = 1'b1;
        m_off_x = '0; m_off_y = '0; m_focal = '0; m_dscale = '0; m_woff = '0;
        m_step  = STEP_RESET;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_directed_extremes();
        test_special_cases();
        test_random_pixels(14, 100);

        drain_pipe();
        if (mismatches == 0 && expected_points.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[files.f]
rtl/core/dpr_pkg.sv
rtl/core/dpr_div_lane.sv
rtl/core/disparity_to_point_reproject.sv
rtl/core/dpr_checker.sv
sim/disparity_to_point_reproject_tb.sv
